// File: rtl/core/rpd_pkg.sv
package rpd_pkg;

    // Header layout
    localparam int HDR_BYTES        = 8;
    localparam int FULL_HDR         = 16;
    localparam int MAX_TRANSFER_DEF = 16384;
    localparam int TLEN_W           = 15;
    localparam logic [31:0] PKT_TYPE_RESET = 32'd1;

    // Result codes
    typedef enum logic [2:0] {
        EV_FRAME  = 3'd0,
        EV_SHORT  = 3'd1,
        EV_TYPE   = 3'd2,
        EV_LENGTH = 3'd3,
        EV_ZERO   = 3'd4,
        EV_TRUNC  = 3'd5
    } rpd_event_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              first_of_transfer;
        logic [TLEN_W-1:0] transfer_length;
    } rpd_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        rpd_event_t event_res;
    } rpd_out_t;

    // Parser result toward the output register
    typedef struct packed {
        logic     valid;
        rpd_out_t item;
    } rpd_res_t;

endpackage

// File: rtl/core/rpd_in_reg.sv
module rpd_in_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rpd_pkg::rpd_in_t s_data,
    input  logic             take,
    output logic             item_valid,
    output rpd_pkg::rpd_in_t item
);
    import rpd_pkg::*;

    logic    valid_reg, valid_next;
    rpd_in_t data_reg;

    // Free when empty or when the held byte moves on this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// File: rtl/core/rpd_parser.sv
module rpd_parser #(
    parameter int MAX_TRANSFER = rpd_pkg::MAX_TRANSFER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic              fire,
    input  rpd_pkg::rpd_in_t  item,
    output rpd_pkg::rpd_res_t res
);
    import rpd_pkg::*;

    localparam int LEFT_W = $clog2(MAX_TRANSFER + 1);
    localparam int POS_W  = $clog2(MAX_TRANSFER + HDR_BYTES);

    logic [31:0]       pkt_type_reg;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              disc_reg, disc_next;
    logic [23:0]       asm_reg, asm_next;
    logic [31:0]       kind_reg, kind_next;
    logic [31:0]       msg_len_reg, msg_len_next;
    logic              off_small_reg, off_small_next;
    logic [32:0]       start_reg, start_next;
    logic [31:0]       end_reg, end_next;

    logic [LEFT_W-1:0] left_v, len_sat;
    logic [POS_W-1:0]  pos_v, pos_inc;
    logic              disc_v;
    logic [31:0]       word;
    logic [32:0]       pos_ext;
    logic [33:0]       end_calc;
    logic [7:0]        b;

    assign b       = item.data_byte;
    assign word    = {b, asm_reg};
    assign pos_ext = 33'(pos_v);
    assign pos_inc = pos_v + POS_W'(1);
    assign end_calc = 34'(start_reg) + 34'(word);

    // Saturate the transfer length
    always_comb begin
        if (32'(item.transfer_length) > 32'(MAX_TRANSFER)) begin
            len_sat = LEFT_W'(MAX_TRANSFER);
        end else begin
            len_sat = LEFT_W'(item.transfer_length);
        end
    end

    // Transfer start overrides the running state
    assign left_v = item.first_of_transfer ? len_sat : left_reg;
    assign pos_v  = item.first_of_transfer ? '0 : pos_reg;
    assign disc_v = item.first_of_transfer ? 1'b0 : disc_reg;

    // Byte parsing
    always_comb begin
        left_next      = left_reg;
        pos_next       = pos_reg;
        disc_next      = disc_reg;
        asm_next       = asm_reg;
        kind_next      = kind_reg;
        msg_len_next   = msg_len_reg;
        off_small_next = off_small_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        res            = '0;
        res.item.event_res = EV_FRAME;

        if (fire) begin
            left_next = left_v;
            pos_next  = pos_v;
            disc_next = disc_v;
            if (left_v != '0) begin
                if (!disc_v) begin
                    asm_next = {b, asm_reg[23:8]};
                    pos_next = pos_inc;
                    if (pos_v == '0 && 32'(left_v) < 32'(HDR_BYTES)) begin
                        res.valid          = 1'b1;
                        res.item.event_res = EV_SHORT;
                    end else if (pos_v == POS_W'(3)) begin
                        kind_next = word;
                    end else if (pos_v == POS_W'(HDR_BYTES - 1)) begin
                        msg_len_next = word;
                        res.valid    = 1'b1;
                        if (kind_reg != pkt_type_reg) begin
                            res.item.event_res = EV_TYPE;
                        end else if (33'(word) > 33'(left_v) + 33'd7) begin
                            res.item.event_res = EV_LENGTH;
                        end else if (word == '0) begin
                            res.item.event_res = EV_ZERO;
                        end else if (word < 32'(FULL_HDR)) begin
                            res.item.event_res = EV_TRUNC;
                        end else begin
                            res.valid = 1'b0;
                        end
                    end else if (pos_v == POS_W'(11)) begin
                        off_small_next = (word < 32'(HDR_BYTES));
                        start_next     = 33'(word) + 33'(HDR_BYTES);
                    end else if (pos_v == POS_W'(FULL_HDR - 1)) begin
                        end_next = end_calc[31:0];
                        if (off_small_reg || end_calc > 34'(msg_len_reg)) begin
                            res.valid          = 1'b1;
                            res.item.event_res = EV_TRUNC;
                        end
                    end else if (pos_v >= POS_W'(FULL_HDR)) begin
                        // Payload window
                        if (pos_ext >= start_reg && pos_ext < 33'(end_reg)) begin
                            res.valid           = 1'b1;
                            res.item.frame_byte = b;
                            res.item.frame_last = (pos_ext + 33'd1) == 33'(end_reg);
                        end
                    end

                    if (res.valid && res.item.event_res != EV_FRAME) begin
                        disc_next = 1'b1;
                        pos_next  = '0;
                    end else if (pos_v >= POS_W'(FULL_HDR - 1)
                                 && 32'(pos_inc) >= msg_len_reg) begin
                        pos_next = '0;
                    end
                end
                left_next = left_v - LEFT_W'(1);
                if (left_v == LEFT_W'(1)) begin
                    disc_next = 1'b0;
                    pos_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_type_reg <= PKT_TYPE_RESET;
            left_reg     <= '0;
            pos_reg      <= '0;
            disc_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pkt_type_reg <= cfg_wr_data;
            end
            left_reg <= left_next;
            pos_reg  <= pos_next;
            disc_reg <= disc_next;
        end
    end

    // Header words, only read after being written within a message
    always_ff @(posedge aclk) begin
        asm_reg       <= asm_next;
        kind_reg      <= kind_next;
        msg_len_reg   <= msg_len_next;
        off_small_reg <= off_small_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
    end

endmodule

// File: rtl/core/rpd_out_reg.sv
module rpd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpd_pkg::rpd_res_t res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output rpd_pkg::rpd_out_t m_data
);
    import rpd_pkg::*;

    logic     valid_reg, valid_next;
    rpd_out_t data_reg;

    // Slot opens when empty or when the held result transfers
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res.valid) begin
            data_reg <= res.item;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: rtl/core/rndis_packet_deframer_unit.sv
// RNDIS packet deframer: takes one bulk-transfer byte per cycle and returns
// payload bytes as frame bytes (frame_last on the final one) or one error
// event per malformed message, after which the rest of the transfer is
// dropped. A byte passes an input register, is parsed combinationally, and
// its result (if any) is registered in an output register, which drives
// m_valid. Throughput is one byte per cycle, limited only by the result
// register draining. No clearing pass is needed after reset. The type
// register may be written only while the block is idle.
module rndis_packet_deframer_unit #(
    parameter int MAX_TRANSFER = rpd_pkg::MAX_TRANSFER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpd_pkg::rpd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rpd_pkg::rpd_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data
);
    import rpd_pkg::*;

    logic     item_valid, out_free, fire;
    rpd_in_t  item;
    rpd_res_t res;

    // A byte is parsed when the result slot can take its outcome
    assign fire = item_valid && out_free;

    rpd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    rpd_parser #(
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (item),
        .res         (res)
    );

    rpd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: tb/sv/tb_rndis_packet_deframer_unit.sv
module tb_rndis_packet_deframer_unit;
    import rpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 70;
    localparam int SETTLE_CYCLES  = 4;

    // Message shapes the bulk transfer builder can produce
    typedef enum int {
        MSG_GOOD,
        MSG_BAD_TYPE,
        MSG_ZERO_LEN,
        MSG_OVER_LEN,
        MSG_SHORT_LEN,
        MSG_LOW_OFFSET,
        MSG_PAST_END
    } msg_shape_t;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_t;

    // Tracks the parser state of the block and the results it owes
    class rndis_frame_tracker;
        logic [31:0] pkt_type;
        logic [31:0] bytes_left;
        logic [31:0] msg_pos;
        logic [31:0] msg_kind;
        logic [31:0] msg_len;
        logic [31:0] pay_off;
        logic [31:0] pay_len;
        bit          dropping;
        rpd_out_t    frames_due[$];
        int          errors;
        int          seen;

        function new();
            pkt_type   = PKT_TYPE_RESET;
            bytes_left = '0;
            msg_pos    = '0;
            msg_kind   = '0;
            msg_len    = '0;
            pay_off    = '0;
            pay_len    = '0;
            dropping   = 1'b0;
            errors     = 0;
            seen       = 0;
        endfunction

        function void set_type(logic [31:0] v);
            pkt_type = v;
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void add_due(logic [7:0] b, logic last, rpd_event_t ev);
            rpd_out_t o;
            o.frame_byte = b;
            o.frame_last = last;
            o.event_res  = ev;
            frames_due.push_back(o);
        endfunction

        // Error: one event, then the rest of the bulk transfer is dropped
        function void abort_msg(rpd_event_t ev);
            dropping = 1'b1;
            msg_pos  = '0;
            add_due(8'h00, 1'b0, ev);
        endfunction

        // One byte of a message: header collection, checks, payload
        function void parse_byte(logic [31:0] b);
            logic [31:0]     p;
            int              sh;
            longint unsigned pay_first;
            longint unsigned pay_end;
            p  = msg_pos;
            sh = 8 * (p % 4);
            if (p == 0) begin
                if (bytes_left < HDR_BYTES) begin
                    abort_msg(EV_SHORT);
                    return;
                end
                msg_kind = '0;
                msg_len  = '0;
                pay_off  = '0;
                pay_len  = '0;
            end
            if (p < 4)
                msg_kind |= b << sh;
            else if (p < 8)
                msg_len |= b << sh;
            else if (p < 12)
                pay_off |= b << sh;
            else if (p < 16)
                pay_len |= b << sh;

            if (p == 7) begin
                if (msg_kind != pkt_type) begin
                    abort_msg(EV_TYPE);
                    return;
                end
                if (msg_len > bytes_left + 32'd7) begin
                    abort_msg(EV_LENGTH);
                    return;
                end
                if (msg_len == 0) begin
                    abort_msg(EV_ZERO);
                    return;
                end
                if (msg_len < FULL_HDR) begin
                    abort_msg(EV_TRUNC);
                    return;
                end
            end else if (p == 15) begin
                // computed in 64 bits so that offset plus length cannot wrap
                pay_end = 64'(HDR_BYTES) + 64'(pay_off) + 64'(pay_len);
                if (pay_off < HDR_BYTES || pay_end > 64'(msg_len)) begin
                    abort_msg(EV_TRUNC);
                    return;
                end
            end else if (p >= FULL_HDR) begin
                pay_first = 64'(HDR_BYTES) + 64'(pay_off);
                pay_end   = pay_first + 64'(pay_len);
                if (64'(p) >= pay_first && 64'(p) < pay_end)
                    add_due(b[7:0], (64'(p) + 1 == pay_end), EV_FRAME);
            end

            if (p >= 15 && p + 1 >= msg_len)
                msg_pos = '0;
            else
                msg_pos = p + 1;
        endfunction

        // Accepted input byte
        function void note_byte(rpd_in_t it);
            if (it.first_of_transfer) begin
                if (it.transfer_length > MAX_TRANSFER_DEF)
                    bytes_left = MAX_TRANSFER_DEF;
                else
                    bytes_left = 32'(it.transfer_length);
                msg_pos  = '0;
                msg_kind = '0;
                msg_len  = '0;
                pay_off  = '0;
                pay_len  = '0;
                dropping = 1'b0;
            end
            if (bytes_left == 0)
                return;
            if (!dropping)
                parse_byte({24'h0, it.data_byte});
            bytes_left--;
            if (bytes_left == 0) begin
                dropping = 1'b0;
                msg_pos  = '0;
            end
        endfunction

        // Accepted result against the oldest one owed
        task check_frame(rpd_out_t got);
            rpd_out_t want;
            seen++;
            if (frames_due.size() == 0) begin
                report($sformatf("result %0d unexpected: byte %h last %0d event %0d",
                                 seen, got.frame_byte, got.frame_last, got.event_res));
                return;
            end
            want = frames_due.pop_front();
            if (got.frame_byte !== want.frame_byte)
                report($sformatf("result %0d frame_byte %h, want %h",
                                 seen, got.frame_byte, want.frame_byte));
            if (got.frame_last !== want.frame_last)
                report($sformatf("result %0d frame_last %0d, want %0d",
                                 seen, got.frame_last, want.frame_last));
            if (got.event_res !== want.event_res)
                report($sformatf("result %0d event_res %0d, want %0d",
                                 seen, got.event_res, want.event_res));
        endtask
    endclass

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    rpd_in_t     s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    rpd_out_t    m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    rndis_frame_tracker tracker;
    logic [7:0]  xfer_bytes[$];
    logic [31:0] cur_type   = PKT_TYPE_RESET;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          idle_cycles = 0;
    rx_mode_t    rx_mode     = RX_OPEN;
    int          rx_mode_left = 0;
    int          rx_tick     = 0;

    rndis_packet_deframer_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Monitor both channels; watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            tracker.note_byte(s_data);
        if (aresetn && m_valid && m_ready)
            tracker.check_frame(m_data);
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver stalls: open, random and periodic stretches
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(24, 160);
        end else begin
            rx_mode_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 2) != 0);
            default:   m_ready <= ((rx_tick % 4) != 3);
        endcase
    end

    // Bulk transfer builder
    function automatic void add_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            xfer_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_random(int n);
        for (int i = 0; i < n; i++)
            xfer_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Appends one message; returns 1 when it is malformed
    function automatic bit add_message(msg_shape_t shape);
        logic [31:0] off;
        logic [31:0] dlen;
        logic [31:0] mlen;
        int          trail;
        case (shape)
            MSG_GOOD: begin
                off   = 8 + (($urandom_range(0, 7) == 0) ? $urandom_range(4, 20)
                                                         : $urandom_range(0, 3));
                dlen  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48)
                                                    : $urandom_range(0, 10);
                trail = $urandom_range(0, 3);
                mlen  = 8 + off + dlen + trail;
                add_word(cur_type);
                add_word(mlen);
                add_word(off);
                add_word(dlen);
                add_random(int'(off) - 8 + int'(dlen) + trail);
                return 1'b0;
            end
            MSG_BAD_TYPE: begin
                if ($urandom_range(0, 2) == 0)
                    add_word($urandom());
                else
                    add_word(cur_type ^ (32'h1 << $urandom_range(0, 31)));
                add_word($urandom_range(16, 40));
            end
            MSG_ZERO_LEN: begin
                add_word(cur_type);
                add_word(32'h0);
            end
            MSG_OVER_LEN: begin
                add_word(cur_type);
                if ($urandom_range(0, 1) == 0)
                    add_word(32'hFFFF_FFFF);
                else
                    add_word($urandom_range(32'hFFFF_FFFE, 16400));
            end
            MSG_SHORT_LEN: begin
                add_word(cur_type);
                add_word($urandom_range(1, 15));
            end
            MSG_LOW_OFFSET: begin
                add_word(cur_type);
                add_word($urandom_range(16, 40));
                add_word($urandom_range(0, 7));
                add_word($urandom_range(0, 8));
            end
            default: begin
                // payload end past the message length, with wrap-prone values at times
                mlen = $urandom_range(16, 40);
                if ($urandom_range(0, 3) == 0)
                    off = 32'hFFFF_FFF8 + $urandom_range(0, 7);
                else
                    off = 8 + $urandom_range(0, mlen - 16);
                if ($urandom_range(0, 3) == 0)
                    dlen = 32'hFFFF_FFFF;
                else
                    dlen = mlen - 8 - off + $urandom_range(1, 4);
                add_word(cur_type);
                add_word(mlen);
                add_word(off);
                add_word(dlen);
            end
        endcase
        add_random($urandom_range(0, 8));
        return 1'b1;
    endfunction

    // Sender: bursts with random gaps; waits for each transfer
    task automatic send_item(input rpd_in_t it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Sends the first n built bytes; flagged marks the first as a new bulk transfer
    task automatic send_bytes(input int declared, input int n, input bit flagged);
        rpd_in_t it;
        for (int i = 0; i < n; i++) begin
            it.data_byte         = xfer_bytes[i];
            it.first_of_transfer = flagged && (i == 0);
            if (it.first_of_transfer)
                it.transfer_length = TLEN_W'(declared);
            else
                it.transfer_length = TLEN_W'($urandom_range(0, 32767));
            send_item(it);
        end
    endtask

    // Mostly well-formed bulk transfers, some with a bad message or odd length
    task automatic run_transfer();
        int         nmsg;
        int         r;
        int         size;
        int         declared;
        int         n_send;
        int         extra;
        msg_shape_t shape;
        xfer_bytes.delete();
        nmsg = $urandom_range(1, 3);
        for (int i = 0; i < nmsg; i++) begin
            shape = ($urandom_range(0, 99) < 85) ? MSG_GOOD
                                                 : msg_shape_t'($urandom_range(1, 6));
            if (add_message(shape))
                break;
        end
        size     = xfer_bytes.size();
        declared = size;
        n_send   = size;
        r        = $urandom_range(0, 99);
        if (r < 70) begin
            declared = size;
        end else if (r < 78) begin
            // short tail left at the start of a message
            extra = $urandom_range(1, 7);
            add_random(extra);
            declared = size + extra;
            n_send   = declared;
        end else if (r < 84) begin
            declared = size - 1;
        end else if (r < 90) begin
            declared = size + $urandom_range(8, 40);
        end else if (r < 93) begin
            declared = $urandom_range(1, 32767);
        end else if (r < 96) begin
            declared = 0;
        end else begin
            n_send = $urandom_range(1, size);
        end
        send_bytes(declared, n_send, 1'b1);

        // stray bytes without a start flag
        if ($urandom_range(0, 7) == 0) begin
            xfer_bytes.delete();
            add_random($urandom_range(1, 4));
            send_bytes(0, xfer_bytes.size(), 1'b0);
        end
    endtask

    // Hold off the sender until every owed result is in, then let the pipe settle
    task automatic wait_for_frames();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_type(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_type(v);
        cur_type = v;
    endtask

    initial begin
        logic [31:0] type_vals[4];
        int          phase_end;
        int          half_way;
        bit          paused;
        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_type(PKT_TYPE_RESET);

        // Directed: one-byte bulk transfer (short remainder)
        xfer_bytes = '{8'hFF};
        send_bytes(1, 1, 1'b1);
        // zero transfer length: byte ignored
        xfer_bytes = '{8'h00};
        send_bytes(0, 1, 1'b1);
        // largest length field, saturated, then abandoned by the next start
        xfer_bytes = '{8'hA5};
        send_bytes(32767, 1, 1'b1);
        // smallest payload-carrying message: one byte, marked last
        xfer_bytes.delete();
        add_word(cur_type);
        add_word(32'd17);
        add_word(32'd8);
        add_word(32'd1);
        xfer_bytes.push_back(8'hFF);
        send_bytes(17, 17, 1'b1);
        // wrong type
        xfer_bytes.delete();
        add_word(~cur_type);
        add_word(32'd16);
        send_bytes(8, 8, 1'b1);
        wait_for_frames();

        // Random phases under several type settings, extremes included
        type_vals = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, $urandom()};
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0)
                write_type(type_vals[ph]);
            phase_end = bytes_sent + PHASE_BYTES;
            half_way  = bytes_sent + PHASE_BYTES / 2;
            paused    = 1'b0;
            while (bytes_sent < phase_end) begin
                run_transfer();
                if (!paused && bytes_sent >= half_way) begin
                    wait_for_frames();
                    paused = 1'b1;
                end
            end
            wait_for_frames();
        end

        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
